>>> rtl/lpe_pkg.sv
// Package for the line position estimator: transaction structs, field widths,
// opcodes, register indexes and register reset values.
// No dependencies.
package lpe_pkg;

  localparam int OPCODE_BITS    = 2;
  localparam int INDEX_BITS     = 3;
  localparam int RAW_BITS       = 12;
  localparam int LEVEL_BITS     = 16;
  localparam int ACTIVE_BITS    = 4;
  localparam int POS_BITS       = 19;
  localparam int WSUM_BITS      = 40;
  localparam int PSUM_BITS      = 20;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MUL_STEPS      = LEVEL_BITS;

  localparam logic [POS_BITS-1:0] POS_TOP = {POS_BITS{1'b1}};

  localparam logic [OPCODE_BITS-1:0] OP_CALIBRATE = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_MEASURE   = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_CLEAR     = 2'd2;

  localparam logic KIND_CAL = 1'b0;
  localparam logic KIND_POS = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_LEVEL     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RUG_LEVEL      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_TOLERANCE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WHITE_LINE     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_SENSORS = 3'd4;

  localparam logic [LEVEL_BITS-1:0]  LINE_LEVEL_RESET     = 16'd1000;
  localparam logic [LEVEL_BITS-1:0]  RUG_LEVEL_RESET      = 16'd0;
  localparam logic [LEVEL_BITS-1:0]  LINE_TOLERANCE_RESET = 16'd300;
  localparam logic                   WHITE_LINE_RESET     = 1'b0;
  localparam logic [ACTIVE_BITS-1:0] ACTIVE_SENSORS_RESET = 4'd8;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    logic [INDEX_BITS-1:0]  sensor_index;
    logic [RAW_BITS-1:0]    sample;
    logic                   last_of_scan;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [POS_BITS-1:0] position;
    logic                line_found;
    logic                calibration_error;
  } out_item_t;

endpackage

>>> rtl/line_position_estimator_top.sv
// Line position estimator: per-sensor min/max calibration, serial map of each
// sample onto rug..line, weighted mean at end of scan. Uses lpe_pkg.
// Measure sample: 16-step multiply, SAMPLE_BITS+16 step divide, clamp, 16-step weight
// multiply, accumulate; zero span goes straight to the weight multiply, inactive is skipped.
// Scan end runs a 40-step divide (at defaults) for the mean, then saturates it.
// Calibrate with last_of_scan adds a table check. Sync reset: config defaults, tables emptied.
module line_position_estimator_top
  import lpe_pkg::*;
#(
  parameter int MAX_SENSORS = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  in_item_t                  sample_item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output out_item_t                 result_item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SB   = SAMPLE_BITS;
  localparam int IW   = $clog2(MAX_SENSORS);
  localparam int CW   = $clog2(MAX_SENSORS + 1);
  localparam int CMPW = (CW > ACTIVE_BITS) ? CW : ACTIVE_BITS;
  localparam int KW   = LEVEL_BITS + INDEX_BITS;
  localparam int PW   = SB + LEVEL_BITS;
  localparam int MW   = (PW > KW + LEVEL_BITS) ? PW : KW + LEVEL_BITS;
  localparam int DVW  = (PW > WSUM_BITS) ? PW : WSUM_BITS;
  localparam int DENW = (SB > PSUM_BITS) ? SB : PSUM_BITS;
  localparam int VW   = PW + 2;
  localparam int CNTW = $clog2(DVW + 1);
  localparam int FARW = CW + LEVEL_BITS;
  localparam int FCW  = (FARW > POS_BITS + 1) ? FARW : POS_BITS + 1;

  localparam logic [SB-1:0] SAMPLE_MAX = {SB{1'b1}};

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_MUL1      = 4'd2;
  localparam logic [3:0] S_DIV1      = 4'd3;
  localparam logic [3:0] S_CLAMP     = 4'd4;
  localparam logic [3:0] S_MUL2      = 4'd5;
  localparam logic [3:0] S_ACCUM     = 4'd6;
  localparam logic [3:0] S_END       = 4'd7;
  localparam logic [3:0] S_DIV2      = 4'd8;
  localparam logic [3:0] S_SAT       = 4'd9;
  localparam logic [3:0] S_CAL_CHECK = 4'd10;
  localparam logic [3:0] S_RESULT    = 4'd11;

  logic [3:0] state;

  // configuration
  logic [LEVEL_BITS-1:0]  line_level;
  logic [LEVEL_BITS-1:0]  rug_level;
  logic [LEVEL_BITS-1:0]  line_tolerance;
  logic                   white_line;
  logic [ACTIVE_BITS-1:0] active_sensors;

  // calibration tables and scan accumulators
  logic [SB-1:0]          max_table [MAX_SENSORS];
  logic [SB-1:0]          min_table [MAX_SENSORS];
  logic [WSUM_BITS-1:0]   weighted_sum;
  logic [PSUM_BITS-1:0]   plain_sum;
  logic                   seen_line;
  logic                   error_seen;
  logic [POS_BITS-1:0]    last_position;

  // latched transaction
  logic [OPCODE_BITS-1:0] op_r;
  logic [INDEX_BITS-1:0]  idx_r;
  logic [SB-1:0]          s_r;
  logic                   last_r;

  // serial datapath
  logic [MW-1:0]          mcand;
  logic [MW-1:0]          acc;
  logic [LEVEL_BITS-1:0]  mplier;
  logic [DVW-1:0]         dq;
  logic [DENW-1:0]        rem;
  logic [DENW-1:0]        den;
  logic [CNTW-1:0]        cnt;
  logic                   q_neg_r;
  logic [LEVEL_BITS-1:0]  o_lo_r;
  logic [LEVEL_BITS-1:0]  x_r;
  out_item_t              pend;

  assign sample_ready = (state == S_IDLE);

  // effective sensor count, clamped to 1..MAX_SENSORS
  logic [CW-1:0] n_eff;
  always_comb begin
    if (active_sensors == '0) begin
      n_eff = CW'(1);
    end else if (CMPW'(active_sensors) > CMPW'(MAX_SENSORS)) begin
      n_eff = CW'(MAX_SENSORS);
    end else begin
      n_eff = CW'(active_sensors);
    end
  end

  logic [IW-1:0] tidx;
  logic          idx_in_table;
  logic          idx_active;
  assign tidx         = IW'(idx_r);
  assign idx_in_table = CMPW'(idx_r) < CMPW'(MAX_SENSORS);
  assign idx_active   = CMPW'(idx_r) < CMPW'(n_eff);

  logic [SB-1:0] tab_lo, tab_hi;
  assign tab_lo = min_table[tidx];
  assign tab_hi = max_table[tidx];

  // signed differences as sign plus magnitude
  logic [SB:0]         diff_w, diff_neg, span_w, span_neg;
  logic [LEVEL_BITS:0] o_w, o_neg;
  logic [SB-1:0]       mag_diff, mag_span;
  logic [LEVEL_BITS-1:0] mag_o;
  assign diff_w   = {1'b0, s_r} - {1'b0, tab_lo};
  assign span_w   = {1'b0, tab_hi} - {1'b0, tab_lo};
  assign o_w      = white_line ? ({1'b0, rug_level} - {1'b0, line_level})
                               : ({1'b0, line_level} - {1'b0, rug_level});
  assign diff_neg = -diff_w;
  assign span_neg = -span_w;
  assign o_neg    = -o_w;
  assign mag_diff = diff_w[SB] ? diff_neg[SB-1:0] : diff_w[SB-1:0];
  assign mag_span = span_w[SB] ? span_neg[SB-1:0] : span_w[SB-1:0];
  assign mag_o    = o_w[LEVEL_BITS] ? o_neg[LEVEL_BITS-1:0] : o_w[LEVEL_BITS-1:0];

  logic [KW-1:0] k_weight;
  assign k_weight = {{LEVEL_BITS{1'b0}}, idx_r} * {{INDEX_BITS{1'b0}}, line_level};

  // shift-add multiplier step
  logic [MW-1:0] acc_next;
  assign acc_next = acc + (mplier[0] ? mcand : '0);

  // restoring divider step
  logic [DENW:0]   rs;
  logic [DENW:0]   rs_sub;
  logic            q_bit;
  logic [DENW-1:0] rem_next;
  logic [DVW-1:0]  dq_next;
  assign rs       = {rem, dq[DVW-1]};
  assign rs_sub   = rs - {1'b0, den};
  assign q_bit    = rs >= {1'b0, den};
  assign rem_next = q_bit ? rs_sub[DENW-1:0] : rs[DENW-1:0];
  assign dq_next  = {dq[DVW-2:0], q_bit};

  // signed mapped value and clamp to rug, then line
  logic [VW-1:0]        qv, v_u;
  logic signed [VW-1:0] cv, rug_v, line_v, t1;
  logic [LEVEL_BITS-1:0] x_clamp;
  always_comb begin
    qv     = VW'(dq[PW-1:0]);
    v_u    = (q_neg_r ? -qv : qv) + VW'(o_lo_r);
    rug_v  = $signed(VW'(rug_level));
    line_v = $signed(VW'(line_level));
    cv     = (state == S_CLAMP) ? $signed(v_u) : rug_v;
    t1     = (cv < rug_v) ? rug_v : cv;
    x_clamp = (t1 > line_v) ? line_level : t1[LEVEL_BITS-1:0];
  end

  // no-line fallback
  logic [FARW-1:0]     far_pos;
  logic [POS_BITS-1:0] far_sat;
  logic                near_start;
  assign far_pos    = FARW'(n_eff - CW'(1)) * FARW'(line_level);
  assign far_sat    = (FCW'(far_pos) > FCW'(POS_TOP)) ? POS_TOP : POS_BITS'(far_pos);
  assign near_start = FCW'({last_position, 1'b0}) < FCW'(far_pos);

  logic [POS_BITS-1:0] mean_sat;
  assign mean_sat = (dq > DVW'(POS_TOP)) ? POS_TOP : dq[POS_BITS-1:0];

  // calibration check over active sensors
  logic cal_bad;
  always_comb begin
    cal_bad = 1'b0;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      if ((CMPW'(i) < CMPW'(n_eff)) && (min_table[i] >= max_table[i])) begin
        cal_bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      line_level     <= LINE_LEVEL_RESET;
      rug_level      <= RUG_LEVEL_RESET;
      line_tolerance <= LINE_TOLERANCE_RESET;
      white_line     <= WHITE_LINE_RESET;
      active_sensors <= ACTIVE_SENSORS_RESET;
      for (int i = 0; i < MAX_SENSORS; i++) begin
        max_table[i] <= '0;
        min_table[i] <= SAMPLE_MAX;
      end
      weighted_sum  <= '0;
      plain_sum     <= '0;
      seen_line     <= 1'b0;
      error_seen    <= 1'b0;
      last_position <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_LINE_LEVEL:     line_level     <= cfg_data[LEVEL_BITS-1:0];
          REG_RUG_LEVEL:      rug_level      <= cfg_data[LEVEL_BITS-1:0];
          REG_LINE_TOLERANCE: line_tolerance <= cfg_data[LEVEL_BITS-1:0];
          REG_WHITE_LINE:     white_line     <= cfg_data[0];
          REG_ACTIVE_SENSORS: active_sensors <= cfg_data[ACTIVE_BITS-1:0];
          default: ;
        endcase
      end

      // S_RESULT handles its own handshake
      if (result_valid && result_ready && (state != S_RESULT)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            op_r   <= sample_item.opcode;
            idx_r  <= sample_item.sensor_index;
            s_r    <= SB'(sample_item.sample);
            last_r <= sample_item.last_of_scan;
            state  <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          unique case (op_r)
            OP_CALIBRATE: begin
              if (idx_in_table) begin
                if (s_r > tab_hi) max_table[tidx] <= s_r;
                if (s_r < tab_lo) min_table[tidx] <= s_r;
              end
              state <= last_r ? S_CAL_CHECK : S_IDLE;
            end
            OP_MEASURE: begin
              if (!idx_active) begin
                state <= last_r ? S_END : S_IDLE;
              end else if (span_w == '0) begin
                // zero span: value is rug, clamped, straight to the weight multiply
                error_seen <= 1'b1;
                x_r    <= x_clamp;
                mcand  <= MW'(k_weight);
                mplier <= x_clamp;
                acc    <= '0;
                cnt    <= CNTW'(MUL_STEPS);
                state  <= S_MUL2;
              end else begin
                mcand   <= MW'(mag_diff);
                mplier  <= mag_o;
                acc     <= '0;
                cnt     <= CNTW'(MUL_STEPS);
                den     <= DENW'(mag_span);
                q_neg_r <= diff_w[SB] ^ span_w[SB] ^ o_w[LEVEL_BITS];
                o_lo_r  <= white_line ? line_level : rug_level;
                state   <= S_MUL1;
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < MAX_SENSORS; i++) begin
                max_table[i] <= '0;
                min_table[i] <= SAMPLE_MAX;
              end
              state <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end

        S_MUL1: begin
          acc    <= acc_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == CNTW'(1)) begin
            // product left-aligned so the quotient lands in the low bits
            dq    <= DVW'(acc_next[PW-1:0]) << (DVW - PW);
            rem   <= '0;
            cnt   <= CNTW'(PW);
            state <= S_DIV1;
          end else begin
            cnt <= cnt - CNTW'(1);
          end
        end

        S_DIV1: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) state <= S_CLAMP;
        end

        S_CLAMP: begin
          x_r    <= x_clamp;
          mcand  <= MW'(k_weight);
          mplier <= x_clamp;
          acc    <= '0;
          cnt    <= CNTW'(MUL_STEPS);
          state  <= S_MUL2;
        end

        S_MUL2: begin
          acc    <= acc_next;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) state <= S_ACCUM;
        end

        S_ACCUM: begin
          weighted_sum <= weighted_sum + WSUM_BITS'(acc);
          plain_sum    <= plain_sum + PSUM_BITS'(x_r);
          if (x_r > line_tolerance) seen_line <= 1'b1;
          state <= last_r ? S_END : S_IDLE;
        end

        S_END: begin
          pend.result_kind       <= KIND_POS;
          pend.line_found        <= seen_line;
          pend.calibration_error <= error_seen;
          weighted_sum <= '0;
          plain_sum    <= '0;
          seen_line    <= 1'b0;
          error_seen   <= 1'b0;
          if (seen_line && (plain_sum != '0)) begin
            dq    <= DVW'(weighted_sum);
            den   <= DENW'(plain_sum);
            rem   <= '0;
            cnt   <= CNTW'(DVW);
            state <= S_DIV2;
          end else if (seen_line || near_start) begin
            pend.position <= '0;
            last_position <= '0;
            state         <= S_RESULT;
          end else begin
            pend.position <= far_sat;
            last_position <= far_sat;
            state         <= S_RESULT;
          end
        end

        S_DIV2: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) state <= S_SAT;
        end

        S_SAT: begin
          pend.position <= mean_sat;
          last_position <= mean_sat;
          state         <= S_RESULT;
        end

        S_CAL_CHECK: begin
          pend.result_kind       <= KIND_CAL;
          pend.position          <= '0;
          pend.line_found        <= 1'b0;
          pend.calibration_error <= cal_bad;
          state                  <= S_RESULT;
        end

        S_RESULT: begin
          // hold until the output register is free
          if (!result_valid || result_ready) begin
            result_item  <= pend;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
